/* rtl/jsdp_pkg.sv */
// Shared types, codes and constants for the joystick sector drive PWM block.
// No dependencies; used by every module in rtl/.
package jsdp_pkg;

    localparam int RAW_W   = 8;
    localparam int POS_W   = 10;  // centered and offset joystick position, signed
    localparam int MAG_W   = 9;
    localparam int SPEED_W = 5;
    localparam int DUTY_W  = 6;
    localparam int CNT_W   = 7;
    localparam int PINS    = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [CNT_W-1:0] PWM_TOP = 7'd100;
    localparam logic [MAG_W-1:0] SPEED_BOOST_LIMIT = 9'd85;
    localparam logic [MAG_W-1:0] SPEED_BOOST = 9'd100;
    localparam logic [MAG_W-1:0] SPEED_SAT = 9'd127;

    localparam logic signed [POS_W-1:0] RAW_CENTER = 10'sd128;
    localparam logic signed [POS_W-1:0] X_NEAR = 10'sd10;
    localparam logic signed [POS_W-1:0] X_LOW  = 10'sd30;
    localparam logic signed [POS_W-1:0] X_MID  = 10'sd50;
    localparam logic signed [POS_W-1:0] X_HIGH = 10'sd70;
    localparam logic signed [POS_W-1:0] X_EAST_MAX = 10'sd100;
    localparam logic signed [POS_W-1:0] X_SWW_MIN  = -10'sd80;
    localparam logic signed [POS_W-1:0] X_WEST_MIN = -10'sd110;

    // Reciprocal multipliers for s/3 and s/5 on 5-bit speeds
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP3 = 13'd171;
    localparam logic [RECIP_W-1:0] RECIP5 = 13'd205;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic CFG_OFFSET_X = 1'b0;
    localparam logic CFG_OFFSET_Y = 1'b1;

    localparam logic [1:0] PIN_LF = 2'd0;
    localparam logic [1:0] PIN_LR = 2'd1;
    localparam logic [1:0] PIN_RF = 2'd2;
    localparam logic [1:0] PIN_RR = 2'd3;

    typedef enum logic [3:0] {
        H_N   = 4'd0,  H_S   = 4'd1,  H_NNE = 4'd2,  H_NNW = 4'd3,
        H_NE  = 4'd4,  H_NW  = 4'd5,  H_NEE = 4'd6,  H_NWW = 4'd7,
        H_E   = 4'd8,  H_W   = 4'd9,  H_SSE = 4'd10, H_SSW = 4'd11,
        H_SE  = 4'd12, H_SW  = 4'd13, H_SEE = 4'd14, H_SWW = 4'd15
    } heading_t;

    typedef logic [DUTY_W-1:0] duty_t;
    typedef duty_t [PINS-1:0] duty_set_t;

    typedef struct packed {
        heading_t             heading;
        logic [SPEED_W-1:0]   speed;
    } steer_t;

endpackage

/* rtl/joystick_sector_drive_pwm_top.sv */
// Top level of the joystick sector drive PWM block: input and result registers, state.
// Depends on jsdp_pkg, jsdp_steer and jsdp_duty.
//
// Usage:
//   s_ channel: one request per item. s_tuser is the opcode (0 sample, 1 tick);
//   s_tdata carries raw_x and raw_y. Ticks only step the PWM counter (0..100).
//   m_ channel: exactly one result per request, in order: four pin levels, the
//   held direction sector and the held speed.
//   cfg channel: writes the x rest bias (index 0) or the y rest bias (index 1);
//   always ready. Write it only while no request is in flight.
// Pipeline: a request taken on s_ is held in the input register, then its
//   result in the result register, which drives m_ (two register stages).
// Throughput: one request per cycle sustained while m_ is not stalled, samples
//   and ticks alike; the whole decode, duty pick and pin compare sit between the two registers.
// Stall: when m_tready is low the result register holds, the input register
//   fills, and s_tready drops once both are full; nothing is lost.
// Reset: aresetn low clears both stages, counter, duties, sector (north),
//   speed and offsets. All pins then read 1 until the first tick.
module joystick_sector_drive_pwm_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jsdp_pkg::IN_DATA_W-1:0]      s_tdata,   // raw_x[7:0], raw_y[15:8]
    input  logic                                s_tuser,   // opcode[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_forward_pin[0], left_reverse_pin[1], right_forward_pin[2],
    // right_reverse_pin[3], heading_code[7:4], drive_speed[12:8], zero[15:13]
    output logic [jsdp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [jsdp_pkg::RAW_W-1:0]          cfg_data
);

    logic in_valid_reg, in_valid_next;
    logic in_op_reg;
    logic [jsdp_pkg::RAW_W-1:0] in_x_reg, in_y_reg;
    logic m_valid_reg, m_valid_next;
    logic [jsdp_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [jsdp_pkg::RAW_W-1:0] bias_x_reg, bias_x_next;
    logic [jsdp_pkg::RAW_W-1:0] bias_y_reg, bias_y_next;
    logic [jsdp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    jsdp_pkg::duty_set_t duty_reg, duty_next;
    jsdp_pkg::steer_t held_reg, held_next;

    jsdp_pkg::steer_t steer_new;
    jsdp_pkg::duty_set_t duty_new;
    logic out_ready, s_fire, work_fire;
    logic [jsdp_pkg::PINS-1:0] pins;

    jsdp_steer u_steer (
        .raw_x  (in_x_reg),
        .raw_y  (in_y_reg),
        .bias_x (bias_x_reg),
        .bias_y (bias_y_reg),
        .steer  (steer_new)
    );

    jsdp_duty u_duty (
        .steer (steer_new),
        .duty  (duty_new)
    );

    assign out_ready = !m_valid_reg || m_tready;
    assign work_fire = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        bias_x_next = bias_x_reg;
        bias_y_next = bias_y_reg;
        if (cfg_valid) begin
            case (cfg_index)
                jsdp_pkg::CFG_OFFSET_X: bias_x_next = cfg_data;
                jsdp_pkg::CFG_OFFSET_Y: bias_y_next = cfg_data;
                default: bias_x_next = bias_x_reg;
            endcase
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        duty_next = duty_reg;
        held_next = held_reg;
        if (work_fire) begin
            case (in_op_reg)
                jsdp_pkg::OP_TICK: begin
                    cnt_next = (cnt_reg >= jsdp_pkg::PWM_TOP) ? '0 : cnt_reg + 7'd1;
                end
                default: begin
                    duty_next = duty_new;
                    held_next = steer_new;
                end
            endcase
        end
        for (int i = 0; i < jsdp_pkg::PINS; i++) begin
            pins[i] = (cnt_next <= {1'b0, duty_next[i]});
        end
        m_data_next = {3'b000, held_next.speed, held_next.heading, pins};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (work_fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (work_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            bias_x_reg   <= '0;
            bias_y_reg   <= '0;
            cnt_reg      <= '0;
            duty_reg     <= '0;
            held_reg     <= '{heading: jsdp_pkg::H_N, speed: '0};
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            bias_x_reg   <= bias_x_next;
            bias_y_reg   <= bias_y_next;
            cnt_reg      <= cnt_next;
            duty_reg     <= duty_next;
            held_reg     <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg <= s_tuser;
            in_x_reg  <= s_tdata[7:0];
            in_y_reg  <= s_tdata[15:8];
        end
        if (work_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // counter stays within the PWM period
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= jsdp_pkg::PWM_TOP)
        else $error("PWM counter above top");

    // a tick leaves sector, speed and duties alone
    a_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (work_fire && in_op_reg == jsdp_pkg::OP_TICK)
        |=> ($stable(held_reg) && $stable(duty_reg)))
        else $error("tick changed steering state");

    // north drives both forward pins equally, reverse pins off
    a_north_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg.heading == jsdp_pkg::H_N)
        |-> (duty_reg[jsdp_pkg::PIN_LF] == duty_reg[jsdp_pkg::PIN_RF]
             && duty_reg[jsdp_pkg::PIN_LR] == '0 && duty_reg[jsdp_pkg::PIN_RR] == '0))
        else $error("north duties inconsistent");

    // a result taken with nothing behind it empties the output stage
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && !in_valid_reg) |=> !m_valid_reg)
        else $error("result repeated");

endmodule

/* rtl/jsdp_steer.sv */
// Joystick sample decode: centering, offset removal, speed and direction sector.
// Depends on jsdp_pkg.
module jsdp_steer (
    input  logic [jsdp_pkg::RAW_W-1:0] raw_x,
    input  logic [jsdp_pkg::RAW_W-1:0] raw_y,
    input  logic [jsdp_pkg::RAW_W-1:0] bias_x,
    input  logic [jsdp_pkg::RAW_W-1:0] bias_y,
    output jsdp_pkg::steer_t           steer
);

    logic signed [jsdp_pkg::POS_W-1:0] x;
    logic signed [jsdp_pkg::POS_W-1:0] y;
    logic signed [jsdp_pkg::POS_W-1:0] x_neg;
    logic signed [jsdp_pkg::POS_W-1:0] y_neg;
    logic [jsdp_pkg::MAG_W-1:0] ax;
    logic [jsdp_pkg::MAG_W-1:0] ay;
    logic [jsdp_pkg::MAG_W-1:0] raw_speed;
    logic [jsdp_pkg::MAG_W-1:0] sat_speed;
    logic fwd;
    jsdp_pkg::heading_t heading;

    assign x = $signed({2'b00, raw_x}) - jsdp_pkg::RAW_CENTER
             - $signed({{2{bias_x[7]}}, bias_x});
    assign y = $signed({2'b00, raw_y}) - jsdp_pkg::RAW_CENTER
             - $signed({{2{bias_y[7]}}, bias_y});
    assign x_neg = -x;
    assign y_neg = -y;
    assign ax = x[jsdp_pkg::POS_W-1] ? x_neg[jsdp_pkg::MAG_W-1:0] : x[jsdp_pkg::MAG_W-1:0];
    assign ay = y[jsdp_pkg::POS_W-1] ? y_neg[jsdp_pkg::MAG_W-1:0] : y[jsdp_pkg::MAG_W-1:0];

    always_comb begin
        if (ay > ax) begin
            raw_speed = (ay > jsdp_pkg::SPEED_BOOST_LIMIT) ? jsdp_pkg::SPEED_BOOST : ay;
        end else begin
            raw_speed = ax;
        end
        // saturate instead of wrapping, then quarter
        sat_speed = (raw_speed > jsdp_pkg::SPEED_SAT) ? jsdp_pkg::SPEED_SAT : raw_speed;
    end

    assign fwd = (y > 10'sd0);

    always_comb begin
        if (y == 10'sd0) begin
            heading = jsdp_pkg::H_N;
        end else if (x < jsdp_pkg::X_NEAR && x > -jsdp_pkg::X_NEAR) begin
            heading = fwd ? jsdp_pkg::H_N : jsdp_pkg::H_S;
        end else if (x > jsdp_pkg::X_NEAR && x <= jsdp_pkg::X_LOW) begin
            heading = fwd ? jsdp_pkg::H_NNE : jsdp_pkg::H_SSE;
        end else if (x > jsdp_pkg::X_LOW && x <= jsdp_pkg::X_MID) begin
            heading = fwd ? jsdp_pkg::H_NE : jsdp_pkg::H_SE;
        end else if (x > jsdp_pkg::X_MID && x <= jsdp_pkg::X_HIGH) begin
            heading = fwd ? jsdp_pkg::H_NEE : jsdp_pkg::H_SEE;
        end else if (x > jsdp_pkg::X_HIGH && x <= jsdp_pkg::X_EAST_MAX) begin
            heading = jsdp_pkg::H_E;
        end else if (x < -jsdp_pkg::X_NEAR && x >= -jsdp_pkg::X_LOW) begin
            heading = fwd ? jsdp_pkg::H_NNW : jsdp_pkg::H_SSW;
        end else if (x < -jsdp_pkg::X_LOW && x >= -jsdp_pkg::X_MID) begin
            heading = fwd ? jsdp_pkg::H_NW : jsdp_pkg::H_SW;
        end else if (fwd) begin
            if (x < -jsdp_pkg::X_MID && x >= -jsdp_pkg::X_HIGH) begin
                heading = jsdp_pkg::H_NWW;
            end else if (x < -jsdp_pkg::X_HIGH && x >= jsdp_pkg::X_WEST_MIN) begin
                heading = jsdp_pkg::H_W;
            end else begin
                heading = jsdp_pkg::H_N;
            end
        end else begin
            if (x < -jsdp_pkg::X_MID && x >= jsdp_pkg::X_SWW_MIN) begin
                heading = jsdp_pkg::H_SWW;
            end else if (x < jsdp_pkg::X_SWW_MIN && x >= jsdp_pkg::X_WEST_MIN) begin
                heading = jsdp_pkg::H_W;
            end else begin
                heading = jsdp_pkg::H_N;
            end
        end
    end

    assign steer.heading = heading;
    assign steer.speed   = sat_speed[6:2];

endmodule

/* rtl/jsdp_duty.sv */
// Duty selection: maps a direction sector and speed to the four pin duties.
// Depends on jsdp_pkg.
module jsdp_duty (
    input  jsdp_pkg::steer_t    steer,
    output jsdp_pkg::duty_set_t duty
);

    logic [jsdp_pkg::SPEED_W-1:0] s;
    logic [jsdp_pkg::RECIP_W-1:0] t3_prod;
    logic [jsdp_pkg::RECIP_W-1:0] f5_prod;
    jsdp_pkg::duty_t sp;
    jsdp_pkg::duty_t d2;
    jsdp_pkg::duty_t h2;
    jsdp_pkg::duty_t t3;
    jsdp_pkg::duty_t f5;

    assign s = steer.speed;
    assign t3_prod = jsdp_pkg::RECIP_W'(s) * jsdp_pkg::RECIP3;
    assign f5_prod = jsdp_pkg::RECIP_W'(s) * jsdp_pkg::RECIP5;

    assign sp = {1'b0, s};
    assign d2 = {s, 1'b0};
    assign h2 = {2'b00, s[4:1]};
    assign t3 = {2'b00, t3_prod[12:9]};
    assign f5 = {3'b000, f5_prod[12:10]};

    // order per entry: left fwd, left rev, right fwd, right rev
    always_comb begin
        duty = '0;
        case (steer.heading)
            jsdp_pkg::H_N: begin
                duty[jsdp_pkg::PIN_LF] = sp; duty[jsdp_pkg::PIN_RF] = sp;
            end
            jsdp_pkg::H_S: begin
                duty[jsdp_pkg::PIN_LR] = sp; duty[jsdp_pkg::PIN_RR] = sp;
            end
            jsdp_pkg::H_E: begin
                duty[jsdp_pkg::PIN_LF] = sp; duty[jsdp_pkg::PIN_RR] = sp;
            end
            jsdp_pkg::H_W: begin
                duty[jsdp_pkg::PIN_LR] = sp; duty[jsdp_pkg::PIN_RF] = sp;
            end
            jsdp_pkg::H_NNE: begin
                duty[jsdp_pkg::PIN_LF] = sp; duty[jsdp_pkg::PIN_RF] = h2;
            end
            jsdp_pkg::H_NNW: begin
                duty[jsdp_pkg::PIN_LF] = h2; duty[jsdp_pkg::PIN_RF] = sp;
            end
            jsdp_pkg::H_NE: begin
                duty[jsdp_pkg::PIN_LF] = d2; duty[jsdp_pkg::PIN_RF] = t3;
            end
            jsdp_pkg::H_NW: begin
                duty[jsdp_pkg::PIN_LF] = t3; duty[jsdp_pkg::PIN_RF] = d2;
            end
            jsdp_pkg::H_NEE: begin
                duty[jsdp_pkg::PIN_LF] = sp; duty[jsdp_pkg::PIN_RF] = f5;
            end
            jsdp_pkg::H_NWW: begin
                duty[jsdp_pkg::PIN_LF] = f5; duty[jsdp_pkg::PIN_RF] = sp;
            end
            jsdp_pkg::H_SSE: begin
                duty[jsdp_pkg::PIN_LR] = sp; duty[jsdp_pkg::PIN_RR] = h2;
            end
            jsdp_pkg::H_SSW: begin
                duty[jsdp_pkg::PIN_LR] = h2; duty[jsdp_pkg::PIN_RR] = sp;
            end
            jsdp_pkg::H_SE: begin
                duty[jsdp_pkg::PIN_LR] = sp; duty[jsdp_pkg::PIN_RR] = t3;
            end
            jsdp_pkg::H_SW: begin
                duty[jsdp_pkg::PIN_LR] = t3; duty[jsdp_pkg::PIN_RR] = sp;
            end
            jsdp_pkg::H_SEE: begin
                duty[jsdp_pkg::PIN_LR] = sp; duty[jsdp_pkg::PIN_RR] = f5;
            end
            default: begin
                duty[jsdp_pkg::PIN_LR] = f5; duty[jsdp_pkg::PIN_RR] = sp;
            end
        endcase
    end

endmodule
